FILE: sv/dlc_pkg.sv
// Shared constants and types for the debounced LED chaser.
`default_nettype none

package dlc_pkg;

  // Field and register widths
  localparam int unsigned STEP_PERIOD_W  = 16;
  localparam int unsigned BOUNCE_DELAY_W = 8;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned CFG_INDEX_W    = 1;
  localparam int unsigned LED_PATTERN_W  = 5;
  localparam int unsigned CHASE_MODE_W   = 2;

  // Default ring size
  localparam int unsigned LED_COUNT_DEF = 5;

  // Register values after reset
  localparam logic [STEP_PERIOD_W-1:0]  STEP_PERIOD_RST  = 16'd50;
  localparam logic [BOUNCE_DELAY_W-1:0] BOUNCE_DELAY_RST = 8'd5;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_PERIOD  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BOUNCE_DELAY = 1'b1;

  // Debouncer phases; the fourth code is never entered and acts as open
  typedef enum logic [1:0] {
    PH_OPEN   = 2'd0,
    PH_CLOSED = 2'd1,
    PH_BOUNCE = 2'd2
  } phase_t;

  // Chase modes as seen on the result channel
  typedef enum logic [CHASE_MODE_W-1:0] {
    MODE_LIT_UP    = 2'd0,
    MODE_LIT_DOWN  = 2'd1,
    MODE_UNLIT_DOWN = 2'd2,
    MODE_UNLIT_UP  = 2'd3
  } mode_t;

endpackage

`default_nettype wire

FILE: sv/debounced_led_chaser_unit.sv
// Top level of the debounced LED chaser: debouncer, step timer, mode machine and LED ring.
`default_nettype none

// Each input item is one poll tick and yields exactly one result item. The tick is worked
// out combinationally: the state registers update at the edge that accepts the item and
// the result lands in a one-deep output register at the same edge. One item is accepted
// per clock; in_ready drops only while the output register holds a result that is not
// taken in that cycle, so the sustained rate is set by the consumer and is one item per
// clock when out_ready stays high. Configuration writes take effect on the next tick; a
// new step period is used at the next timer reload.
module debounced_led_chaser_unit #(
  parameter int unsigned LED_COUNT = dlc_pkg::LED_COUNT_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // configuration port
  input  wire                                   cfg_we,
  input  wire  [dlc_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire  [dlc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  // input channel
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire                                   in_button_one_level,
  input  wire                                   in_button_five_event,
  // result channel
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [dlc_pkg::LED_PATTERN_W-1:0]     out_led_pattern,
  output logic [dlc_pkg::CHASE_MODE_W-1:0]      out_chase_mode
);

  localparam int unsigned POS_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [POS_W:0]   LED_COUNT_EXT = (POS_W + 1)'(LED_COUNT);
  localparam logic [POS_W-1:0] POS_LAST      = POS_W'(LED_COUNT - 1);

  // Configuration registers
  logic [dlc_pkg::STEP_PERIOD_W-1:0]  step_period_r;
  logic [dlc_pkg::BOUNCE_DELAY_W-1:0] bounce_delay_r;

  // Tick state
  dlc_pkg::phase_t                    phase_r, phase_nxt;
  logic [dlc_pkg::BOUNCE_DELAY_W-1:0] bounce_count_r, bounce_count_nxt;
  logic [dlc_pkg::STEP_PERIOD_W-1:0]  step_timer_r, step_timer_nxt;
  logic [POS_W-1:0]                   pos_r, pos_nxt;
  dlc_pkg::mode_t                     mode_r, mode_nxt;
  logic [LED_COUNT-1:0]               led_r, led_nxt;

  // Result register
  logic                               out_valid_r;
  logic [dlc_pkg::LED_PATTERN_W-1:0]  out_led_pattern_r;
  logic [dlc_pkg::CHASE_MODE_W-1:0]   out_chase_mode_r;

  logic                               in_acc;
  logic                               press_one;
  logic                               step_now;
  logic                               upward;
  logic                               lit;
  logic [dlc_pkg::BOUNCE_DELAY_W-1:0] bounce_dec;
  logic [dlc_pkg::STEP_PERIOD_W-1:0]  timer_dec;
  logic [POS_W:0]                     pos_inc;
  logic [LED_COUNT-1:0]               onehot;
  logic [dlc_pkg::LED_PATTERN_W-1:0]  pattern_nxt;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_led_pattern = out_led_pattern_r;
  assign out_chase_mode  = out_chase_mode_r;

  // Debouncer: the counter runs down before the phase is examined.
  always_comb begin
    bounce_dec       = (bounce_count_r != '0) ? bounce_count_r - 1'b1 : bounce_count_r;
    bounce_count_nxt = bounce_dec;
    phase_nxt        = phase_r;
    press_one        = 1'b0;
    case (phase_r)
      dlc_pkg::PH_CLOSED: begin
        if (!in_button_one_level) begin
          phase_nxt        = dlc_pkg::PH_BOUNCE;
          bounce_count_nxt = bounce_delay_r;
        end
      end
      dlc_pkg::PH_BOUNCE: begin
        if (in_button_one_level) begin
          phase_nxt = dlc_pkg::PH_CLOSED;
        end else if (bounce_dec == '0) begin
          phase_nxt = dlc_pkg::PH_OPEN;
        end
      end
      default: begin
        if (in_button_one_level) begin
          phase_nxt = dlc_pkg::PH_CLOSED;
          press_one = 1'b1;
        end
      end
    endcase
  end

  // Step timer and ring; the step uses the mode held before this tick's presses.
  always_comb begin
    timer_dec = (step_timer_r != '0) ? step_timer_r - 1'b1 : step_timer_r;
    step_now  = (timer_dec == '0);
    step_timer_nxt = step_now ? step_period_r : timer_dec;

    upward  = (mode_r == dlc_pkg::MODE_LIT_UP) || (mode_r == dlc_pkg::MODE_UNLIT_UP);
    lit     = (mode_r == dlc_pkg::MODE_LIT_UP) || (mode_r == dlc_pkg::MODE_LIT_DOWN);
    pos_inc = {1'b0, pos_r} + 1'b1;

    pos_nxt = pos_r;
    if (step_now) begin
      if (upward) begin
        pos_nxt = (pos_inc >= LED_COUNT_EXT) ? '0 : pos_inc[POS_W-1:0];
      end else if (pos_r == '0 || {1'b0, pos_r} > LED_COUNT_EXT) begin
        pos_nxt = POS_LAST;
      end else begin
        pos_nxt = pos_r - 1'b1;
      end
    end

    onehot  = LED_COUNT'(1) << pos_nxt;
    led_nxt = step_now ? (lit ? onehot : ~onehot) : led_r;
  end

  // Mode machine. With both presses in one tick the later assignment wins, which gives
  // the fixed order of the mode table.
  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      dlc_pkg::MODE_LIT_UP: begin
        if (press_one) mode_nxt = dlc_pkg::MODE_LIT_DOWN;
        if (in_button_five_event) mode_nxt = dlc_pkg::MODE_UNLIT_UP;
      end
      dlc_pkg::MODE_LIT_DOWN: begin
        if (press_one) mode_nxt = dlc_pkg::MODE_LIT_UP;
        if (in_button_five_event) mode_nxt = dlc_pkg::MODE_UNLIT_DOWN;
      end
      dlc_pkg::MODE_UNLIT_DOWN: begin
        if (press_one) mode_nxt = dlc_pkg::MODE_UNLIT_UP;
        if (in_button_five_event) mode_nxt = dlc_pkg::MODE_LIT_DOWN;
      end
      default: begin
        if (in_button_five_event) mode_nxt = dlc_pkg::MODE_LIT_UP;
        if (press_one) mode_nxt = dlc_pkg::MODE_UNLIT_DOWN;
      end
    endcase
  end

  // Only the low LEDs reach the pattern port; missing LEDs read as dark.
  genvar k;
  generate
    for (k = 0; k < dlc_pkg::LED_PATTERN_W; k++) begin : g_pat
      if (k < LED_COUNT) begin : g_led
        assign pattern_nxt[k] = led_nxt[k];
      end else begin : g_none
        assign pattern_nxt[k] = 1'b0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_period_r  <= dlc_pkg::STEP_PERIOD_RST;
      bounce_delay_r <= dlc_pkg::BOUNCE_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dlc_pkg::CFG_STEP_PERIOD:  step_period_r  <= cfg_wdata[dlc_pkg::STEP_PERIOD_W-1:0];
        dlc_pkg::CFG_BOUNCE_DELAY: bounce_delay_r <= cfg_wdata[dlc_pkg::BOUNCE_DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= dlc_pkg::PH_OPEN;
      bounce_count_r    <= '0;
      step_timer_r      <= dlc_pkg::STEP_PERIOD_RST;
      pos_r             <= '0;
      mode_r            <= dlc_pkg::MODE_LIT_UP;
      led_r             <= LED_COUNT'(1);
      out_valid_r       <= 1'b0;
      out_led_pattern_r <= '0;
      out_chase_mode_r  <= '0;
    end else begin
      if (in_acc) begin
        phase_r           <= phase_nxt;
        bounce_count_r    <= bounce_count_nxt;
        step_timer_r      <= step_timer_nxt;
        pos_r             <= pos_nxt;
        mode_r            <= mode_nxt;
        led_r             <= led_nxt;
        out_valid_r       <= 1'b1;
        out_led_pattern_r <= pattern_nxt;
        out_chase_mode_r  <= mode_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The ring position never leaves the ring.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pos_r} < LED_COUNT_EXT)
    else $error("ring position outside the ring");

  // A step in a lit mode leaves exactly one LED on.
  a_lit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && step_now && lit |=> $onehot(led_r))
    else $error("lit step did not give a single LED");

  // A step in an unlit mode leaves exactly one LED dark.
  a_unlit_one_dark: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && step_now && !lit |=> $countones(led_r) == LED_COUNT - 1)
    else $error("unlit step did not give a single dark LED");

  // Tick state moves only when an item is accepted.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(mode_r) && $stable(pos_r) && $stable(step_timer_r))
    else $error("tick state changed without an item");

  // A press event is only raised from the open phase.
  a_press_open: assert property (@(posedge clk) disable iff (!rst_n)
    press_one |-> phase_r != dlc_pkg::PH_CLOSED && phase_r != dlc_pkg::PH_BOUNCE)
    else $error("press event outside the open phase");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the debounced LED chaser unit, with a cycle-free predictor.
module testbench;

  localparam int unsigned RING        = dlc_pkg::LED_COUNT_DEF;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned N_DIRECTED  = 24;
  localparam int unsigned N_PHASES    = 8;

  typedef struct packed {
    logic [dlc_pkg::LED_PATTERN_W-1:0] led;
    dlc_pkg::mode_t                    mode;
  } chase_out_t;

  typedef struct packed {
    logic                              lvl;
    logic                              ev5;
    logic                              typed;
    logic [dlc_pkg::LED_PATTERN_W-1:0] led;
    dlc_pkg::mode_t                    mode;
  } poll_row_t;

  typedef struct packed {
    int unsigned period;
    int unsigned delay;
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned items;
  } phase_row_t;

  // Bounce delay is one during this table, so a release needs two open ticks.
  // Presses with both buttons are made from each of the four modes in turn.
  localparam poll_row_t DIRECTED [N_DIRECTED] = '{
    '{1'b0, 1'b0, 1'b1, 5'b00001, dlc_pkg::MODE_LIT_UP},
    '{1'b1, 1'b1, 1'b1, 5'b00001, dlc_pkg::MODE_UNLIT_UP},
    '{1'b0, 1'b0, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b0, 1'b0, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b1, 1'b1, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b0, 1'b0, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b0, 1'b0, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b1, 1'b1, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b0, 1'b0, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b0, 1'b0, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b1, 1'b1, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b0, 1'b1, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b1, 1'b0, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b0, 1'b0, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b0, 1'b1, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b1, 1'b0, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b1, 1'b0, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b0, 1'b0, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b0, 1'b0, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b0, 1'b1, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b1, 1'b0, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b0, 1'b0, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b0, 1'b0, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP},
    '{1'b1, 1'b0, 1'b0, 5'b00000, dlc_pkg::MODE_LIT_UP}
  };

  localparam phase_row_t PHASES [N_PHASES] = '{
    '{0,     0,   0,  0,  160},
    '{1,     255, 61, 0,  160},
    '{3,     2,   0,  61, 150},
    '{65535, 7,   16, 16, 120},
    '{7,     1,   0,  0,  150},
    '{2,     0,   61, 0,  150},
    '{0,     3,   0,  61, 150},
    '{50,    5,   16, 16, 186}
  };

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [dlc_pkg::CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [dlc_pkg::CFG_DATA_W-1:0]    cfg_wdata = '0;
  logic                              in_valid = 1'b0;
  wire                               in_ready;
  logic                              in_button_one_level = 1'b0;
  logic                              in_button_five_event = 1'b0;
  wire                               out_valid;
  logic                              out_ready = 1'b1;
  wire  [dlc_pkg::LED_PATTERN_W-1:0] out_led_pattern;
  wire  [dlc_pkg::CHASE_MODE_W-1:0]  out_chase_mode;

  // Hand-typed result that goes with the item currently on the input channel.
  logic                              tick_typed = 1'b0;
  logic [dlc_pkg::LED_PATTERN_W-1:0] tick_led_ref = '0;
  dlc_pkg::mode_t                    tick_mode_ref = dlc_pkg::MODE_LIT_UP;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  chase_out_t pattern_queue [$];

  // Predicted chaser state and register copies.
  dlc_pkg::phase_t                    db_phase;
  logic [dlc_pkg::BOUNCE_DELAY_W-1:0] db_count;
  logic [dlc_pkg::STEP_PERIOD_W-1:0]  step_timer_q;
  logic [2:0]                         ring_pos;
  dlc_pkg::mode_t                     chase_mode_q;
  logic [dlc_pkg::LED_PATTERN_W-1:0]  led_q;
  logic [dlc_pkg::STEP_PERIOD_W-1:0]  period_q;
  logic [dlc_pkg::BOUNCE_DELAY_W-1:0] delay_q;

  debounced_led_chaser_unit u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_button_one_level  (in_button_one_level),
    .in_button_five_event (in_button_five_event),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_led_pattern      (out_led_pattern),
    .out_chase_mode       (out_chase_mode)
  );

  always #1 clk = ~clk;

  function automatic chase_out_t advance_chaser(input logic lvl, input logic ev5);
    logic                              ev1;
    logic                              upward;
    logic                              lit;
    logic [dlc_pkg::LED_PATTERN_W-1:0] onehot;
    ev1 = 1'b0;
    // The bounce count runs down before the phase is looked at.
    if (db_count != 0) db_count--;
    case (db_phase)
      dlc_pkg::PH_CLOSED: if (!lvl) begin
        db_phase = dlc_pkg::PH_BOUNCE;
        db_count = delay_q;
      end
      dlc_pkg::PH_BOUNCE: if (lvl) db_phase = dlc_pkg::PH_CLOSED;
                          else if (db_count == 0) db_phase = dlc_pkg::PH_OPEN;
      default: if (lvl) begin
        db_phase = dlc_pkg::PH_CLOSED;
        ev1 = 1'b1;
      end
    endcase
    if (step_timer_q != 0) step_timer_q--;
    if (step_timer_q == 0) begin
      // The step uses the mode held before this tick's presses.
      step_timer_q = period_q;
      upward = (chase_mode_q == dlc_pkg::MODE_LIT_UP) ||
               (chase_mode_q == dlc_pkg::MODE_UNLIT_UP);
      lit = (chase_mode_q == dlc_pkg::MODE_LIT_UP) ||
            (chase_mode_q == dlc_pkg::MODE_LIT_DOWN);
      if (upward) ring_pos = (ring_pos + 1 >= RING) ? 3'd0 : ring_pos + 3'd1;
      else ring_pos = (ring_pos == 0) ? 3'(RING - 1) : ring_pos - 3'd1;
      onehot = dlc_pkg::LED_PATTERN_W'(1) << ring_pos;
      led_q = lit ? onehot : ~onehot;
    end
    case (chase_mode_q)
      dlc_pkg::MODE_LIT_UP: begin
        if (ev1) chase_mode_q = dlc_pkg::MODE_LIT_DOWN;
        if (ev5) chase_mode_q = dlc_pkg::MODE_UNLIT_UP;
      end
      dlc_pkg::MODE_LIT_DOWN: begin
        if (ev1) chase_mode_q = dlc_pkg::MODE_LIT_UP;
        if (ev5) chase_mode_q = dlc_pkg::MODE_UNLIT_DOWN;
      end
      dlc_pkg::MODE_UNLIT_DOWN: begin
        if (ev1) chase_mode_q = dlc_pkg::MODE_UNLIT_UP;
        if (ev5) chase_mode_q = dlc_pkg::MODE_LIT_DOWN;
      end
      default: begin
        // Here button one wins when both arrive together.
        if (ev5) chase_mode_q = dlc_pkg::MODE_LIT_UP;
        if (ev1) chase_mode_q = dlc_pkg::MODE_UNLIT_DOWN;
      end
    endcase
    return '{led: led_q, mode: chase_mode_q};
  endfunction

  always @(posedge clk) begin : result_check
    chase_out_t want;
    if (!rst_n) begin
      db_phase     = dlc_pkg::PH_OPEN;
      db_count     = '0;
      period_q     = dlc_pkg::STEP_PERIOD_RST;
      delay_q      = dlc_pkg::BOUNCE_DELAY_RST;
      step_timer_q = dlc_pkg::STEP_PERIOD_RST;
      ring_pos     = 3'd0;
      chase_mode_q = dlc_pkg::MODE_LIT_UP;
      led_q        = dlc_pkg::LED_PATTERN_W'(1);
    end else begin
      if (cfg_we) begin
        if (cfg_index == dlc_pkg::CFG_STEP_PERIOD) period_q = cfg_wdata;
        else if (cfg_index == dlc_pkg::CFG_BOUNCE_DELAY)
          delay_q = cfg_wdata[dlc_pkg::BOUNCE_DELAY_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (pattern_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing pending: led %b mode %0d",
                     $realtime, out_led_pattern, out_chase_mode);
        end else begin
          want = pattern_queue.pop_front();
          if (out_led_pattern !== want.led || out_chase_mode !== want.mode) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected led %b mode %0d, got led %b mode %0d", $realtime,
                       want.led, want.mode, out_led_pattern, out_chase_mode);
          end
        end
      end
      if (in_valid && in_ready) begin
        want = advance_chaser(in_button_one_level, in_button_five_event);
        if (tick_typed) want = '{led: tick_led_ref, mode: tick_mode_ref};
        pattern_queue.push_back(want);
      end
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("debounced_led_chaser_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [dlc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [dlc_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_tick(input logic lvl, input logic ev5, input logic typed,
                           input logic [dlc_pkg::LED_PATTERN_W-1:0] led,
                           input dlc_pkg::mode_t mode);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid             <= 1'b1;
    in_button_one_level  <= lvl;
    in_button_five_event <= ev5;
    tick_typed           <= typed;
    tick_led_ref         <= led;
    tick_mode_ref        <= mode;
    do @(posedge clk); while (!in_ready);
  endtask

  // Button one is held in runs around the bounce delay so that full press and
  // release cycles happen, with the odd single-tick glitch on top.
  task automatic run_random(input int unsigned n);
    int unsigned run_left;
    logic        lvl;
    logic        level_now;
    logic        ev5;
    run_left = 0;
    lvl = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (run_left == 0) begin
        if ($urandom_range(0, 9) != 0) lvl = ~lvl;
        run_left = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, delay_q + 4);
      end
      run_left--;
      level_now = ($urandom_range(0, 15) == 0) ? 1'($urandom_range(0, 1)) : lvl;
      ev5 = ($urandom_range(0, 7) == 0);
      send_tick(level_now, ev5, 1'b0, '0, dlc_pkg::MODE_LIT_UP);
    end
  endtask

  task automatic drain_pipe(input int unsigned settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pattern_queue.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // The upper byte is not part of the register and must be dropped.
    write_reg(dlc_pkg::CFG_BOUNCE_DELAY, 16'hA501);
    for (int i = 0; i < N_DIRECTED; i++)
      send_tick(DIRECTED[i].lvl, DIRECTED[i].ev5, DIRECTED[i].typed,
                DIRECTED[i].led, DIRECTED[i].mode);
    drain_pipe(4);
    for (int p = 0; p < N_PHASES; p++) begin
      idle_pct  = PHASES[p].idle_pct;
      stall_pct = PHASES[p].stall_pct;
      write_reg(dlc_pkg::CFG_STEP_PERIOD, 16'(PHASES[p].period));
      write_reg(dlc_pkg::CFG_BOUNCE_DELAY,
                {8'($urandom_range(0, 255)), 8'(PHASES[p].delay)});
      run_random(PHASES[p].items);
      drain_pipe(4);
    end
    if (mismatches == 0 && pattern_queue.size() == 0) begin
      $display("debounced_led_chaser_unit test passed");
    end else begin
      $display("debounced_led_chaser_unit test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/dlc_pkg.sv
sv/debounced_led_chaser_unit.sv
tb/testbench.sv
